[design/servo_bus_frame_builder_core_assert.svh]
// Assertion macros used by the top level of the servo bus frame builder RTL.
`ifndef SERVO_BUS_FRAME_BUILDER_CORE_ASSERT_SVH
`define SERVO_BUS_FRAME_BUILDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBFB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold after the antecedent, with a longer delay than SBFB_ASSERT_NEXT.
`define SBFB_ASSERT_LATER(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

[design/sbfb_pkg.sv]
// Types and constants of the servo bus frame builder.
package sbfb_pkg;

    localparam int IDX_W = 4;

    // Frame kind codes of a request.
    localparam logic [1:0] CMD_PING  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Fixed frame bytes.
    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] INS_PING  = 8'h01;
    localparam logic [7:0] INS_READ  = 8'h02;
    localparam logic [7:0] INS_WRITE = 8'h03;
    localparam logic [7:0] LEN_PING  = 8'd2;
    localparam logic [7:0] LEN_READ  = 8'd4;
    localparam logic [7:0] LEN_WRITE_BASE = 8'd3;

    // Byte positions within a frame.
    localparam logic [IDX_W-1:0] POS_ID   = 4'd2;
    localparam logic [IDX_W-1:0] POS_LEN  = 4'd3;
    localparam logic [IDX_W-1:0] POS_INS  = 4'd4;
    localparam logic [IDX_W-1:0] POS_ADDR = 4'd5;
    localparam logic [IDX_W-1:0] POS_ARG  = 4'd6;

    // Position of the checksum byte for each frame kind.
    localparam logic [IDX_W-1:0] LAST_PING       = 4'd5;
    localparam logic [IDX_W-1:0] LAST_READ       = 4'd7;
    localparam logic [IDX_W-1:0] LAST_WRITE_BASE = 4'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] servo_id;
        logic [7:0] reg_addr;
        logic [7:0] read_count;
        logic [2:0] data_count;
        logic [7:0] data_0;
        logic [7:0] data_1;
        logic [7:0] data_2;
        logic [7:0] data_3;
        logic [7:0] data_4;
        logic [7:0] data_5;
    } t_sbfb_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_sbfb_res;

    // Controller to datapath.
    typedef struct packed {
        logic             load;
        logic             emit;
        logic             final_byte;
        logic [IDX_W-1:0] idx;
    } t_sbfb_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic             req_ok;
        logic [IDX_W-1:0] req_last_idx;
    } t_sbfb_sts;

endpackage

[design/sbfb_dp.sv]
// Datapath of the servo bus frame builder: request registers, byte select and checksum.
module sbfb_dp
    import sbfb_pkg::*;
#(
    parameter int MAX_WRITE_BYTES = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sbfb_req i_req,
    input  t_sbfb_cmd i_cmd,
    output t_sbfb_sts o_sts,
    output logic      o_valid,
    output t_sbfb_res o_res
);

    logic [7:0] w_in_data [6];
    logic [7:0] r_data [MAX_WRITE_BYTES];
    logic [7:0] r_id;
    logic [7:0] r_addr;
    logic [7:0] r_rcnt;
    logic [7:0] r_len;
    logic [7:0] r_ins;
    logic       r_is_read;
    logic [7:0] r_sum;
    logic [7:0] n_len;
    logic [7:0] n_ins;
    logic [7:0] w_byte;
    logic       w_summed;
    t_sbfb_res  r_res;
    logic       r_valid;

    assign w_in_data[0] = i_req.data_0;
    assign w_in_data[1] = i_req.data_1;
    assign w_in_data[2] = i_req.data_2;
    assign w_in_data[3] = i_req.data_3;
    assign w_in_data[4] = i_req.data_4;
    assign w_in_data[5] = i_req.data_5;

    // Decode of the incoming request.
    always_comb begin
        o_sts.req_ok       = 1'b0;
        o_sts.req_last_idx = LAST_PING;
        n_len              = LEN_PING;
        n_ins              = INS_PING;
        unique case (i_req.cmd)
            CMD_PING: begin
                o_sts.req_ok = 1'b1;
            end
            CMD_READ: begin
                o_sts.req_ok       = 1'b1;
                o_sts.req_last_idx = LAST_READ;
                n_len              = LEN_READ;
                n_ins              = INS_READ;
            end
            CMD_WRITE: begin
                o_sts.req_ok = ({1'b0, i_req.data_count} <= IDX_W'(MAX_WRITE_BYTES));
                o_sts.req_last_idx = IDX_W'({1'b0, i_req.data_count}) + LAST_WRITE_BASE;
                n_len = {5'd0, i_req.data_count} + LEN_WRITE_BASE;
                n_ins = INS_WRITE;
            end
            default: begin
                o_sts.req_ok = 1'b0;
            end
        endcase
    end

    // Byte for the current frame position.
    always_comb begin
        w_byte = HDR_BYTE;
        if (i_cmd.final_byte) begin
            w_byte = ~r_sum;
        end else if (i_cmd.idx == POS_ID) begin
            w_byte = r_id;
        end else if (i_cmd.idx == POS_LEN) begin
            w_byte = r_len;
        end else if (i_cmd.idx == POS_INS) begin
            w_byte = r_ins;
        end else if (i_cmd.idx == POS_ADDR) begin
            w_byte = r_addr;
        end else if (i_cmd.idx == POS_ARG && r_is_read) begin
            w_byte = r_rcnt;
        end else begin
            for (int j = 0; j < MAX_WRITE_BYTES; j++) begin
                if (i_cmd.idx == IDX_W'(POS_ARG + j)) begin
                    w_byte = r_data[j];
                end
            end
        end
    end

    assign w_summed = i_cmd.emit && !i_cmd.final_byte && (i_cmd.idx >= POS_ID);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id      <= i_req.servo_id;
            r_addr    <= i_req.reg_addr;
            r_rcnt    <= i_req.read_count;
            r_len     <= n_len;
            r_ins     <= n_ins;
            r_is_read <= (i_req.cmd == CMD_READ);
            for (int j = 0; j < MAX_WRITE_BYTES; j++) begin
                r_data[j] <= w_in_data[j];
            end
        end
        if (i_cmd.load) begin
            r_sum <= 8'd0;
        end else if (w_summed) begin
            r_sum <= r_sum + w_byte;
        end
        if (i_cmd.emit) begin
            r_res.tx_byte <= w_byte;
            r_res.last    <= i_cmd.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[design/sbfb_ctrl.sv]
// Controller of the servo bus frame builder: request acceptance and byte sequencing.
module sbfb_ctrl
    import sbfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_sbfb_sts i_sts,
    output t_sbfb_cmd o_cmd,
    output logic      o_busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic [IDX_W-1:0] n_last_idx;
    logic             w_final;
    logic             w_accept;

    assign w_final  = (r_state == S_EMIT) && (r_idx == r_last_idx);
    assign o_busy   = (r_state == S_EMIT) && !w_final;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_sts.req_ok) begin
                    n_state    = S_EMIT;
                    n_idx      = '0;
                    n_last_idx = i_sts.req_last_idx;
                end
            end
            S_EMIT: begin
                if (w_accept && i_sts.req_ok) begin
                    n_idx      = '0;
                    n_last_idx = i_sts.req_last_idx;
                end else if (w_final) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    assign o_cmd.load       = w_accept && i_sts.req_ok;
    assign o_cmd.emit       = (r_state == S_EMIT);
    assign o_cmd.final_byte = w_final;
    assign o_cmd.idx        = r_idx;

endmodule

[design/servo_bus_frame_builder_core.sv]
// Top level of the servo bus frame builder: controller, datapath and checks.
//
//  channel   ports                     direction  handshake
//  request   i_start, i_req, o_busy    in         taken when i_start is high and o_busy low
//  result    o_valid, o_res            out        one byte per cycle, no back-pressure
//
// A frame of N bytes (6 for a ping, 8 for a read, 7 plus the data count for a write)
// appears on o_res without gaps; the first byte is shown behind the position counter
// and the output register once the request is taken.
// The next request can be taken at the edge that registers the checksum byte, so
// back-to-back frames run with no gap, at most 13 bytes each, paced by the byte counter.
// A request with an unused kind code or an oversized write is taken and produces nothing.
// The synchronous reset clears the state machine and the result strobe; the receiver
// cannot stall the result stream, and each byte is valid for exactly one cycle.
module servo_bus_frame_builder_core
    import sbfb_pkg::*;
#(
    parameter int MAX_WRITE_BYTES = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_sbfb_req i_req,
    output logic      o_busy,
    output logic      o_valid,
    output t_sbfb_res o_res
);

`include "servo_bus_frame_builder_core_assert.svh"

    // Command and status between the two halves of the design.
    t_sbfb_cmd w_cmd;
    t_sbfb_sts w_sts;

    // The controller owns the frame position counter and decides when a request
    // is taken; the datapath holds the request, picks each byte and keeps the sum.
    sbfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    sbfb_dp #(
        .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // A well-formed request always opens its frame with a header byte.
    `SBFB_ASSERT_LATER(a_frame_opens, i_clk, i_rst_n, i_start && !o_busy && w_sts.req_ok, o_valid && o_res.tx_byte == HDR_BYTE && !o_res.last, "frame did not open with a header byte")
    // Bytes of a frame are contiguous until the checksum byte.
    `SBFB_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_valid && !o_res.last, o_valid, "gap inside a frame")
    // While busy, the block is part way through a frame and must emit next cycle.
    `SBFB_ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, o_busy, o_valid, "busy without emitting")
    // The controller never asks the datapath to load while it is mid-frame.
    `SBFB_ASSERT_SAME(a_load_only_free, i_clk, i_rst_n, w_cmd.load, !o_busy && i_start, "request loaded while busy")

endmodule

[bench/servo_bus_frame_builder_core_test.sv]
// Self-checking testbench that drives frame requests and checks every emitted frame byte.
module servo_bus_frame_builder_core_test;
    import sbfb_pkg::*;

    localparam int MAX_WRITE_BYTES = 6;
    localparam int CYCLE_LIMIT = 100000;
    // Cycles allowed after the last expected byte for the block to fall quiet.
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_REQUESTS = 190;
    // The closing stretch of random requests is sent without any idling.
    localparam int NO_IDLE_FROM = 170;

    // Kind code that the block does not use; such a request yields no frame.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // A request waiting to be sent, with the idling that precedes it and a flag
    // that holds it back until every byte already expected has been seen.
    typedef struct {
        t_sbfb_req req;
        int        idle_cycles;
        bit        wait_drain;
    } t_pending_req;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_sbfb_req i_req = '0;
    logic      o_busy;
    logic      o_valid;
    t_sbfb_res o_res;

    t_pending_req pending_reqs[$];
    t_sbfb_res    frame_bytes[$];
    t_sbfb_res    want_byte;
    int           bytes_outstanding = 0;
    int           requests_taken = 0;
    int           total_requests = 0;
    int           error_count = 0;
    int           idle_left = 0;
    int           cycle_count = 0;

    servo_bus_frame_builder_core #(
        .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Works out the bytes of the frame that a request should produce and appends
    // them to the store of expected bytes. The checksum covers everything from
    // the id onwards, so the two header bytes are kept out of the body.
    task automatic build_frame(input t_sbfb_req req);
        logic [7:0] body[$];
        logic [7:0] data[6];
        logic [7:0] csum;
        csum = 8'h00;
        data[0] = req.data_0;
        data[1] = req.data_1;
        data[2] = req.data_2;
        data[3] = req.data_3;
        data[4] = req.data_4;
        data[5] = req.data_5;
        case (req.cmd)
            CMD_PING: begin
                body.push_back(req.servo_id);
                body.push_back(LEN_PING);
                body.push_back(INS_PING);
            end
            CMD_READ: begin
                body.push_back(req.servo_id);
                body.push_back(LEN_READ);
                body.push_back(INS_READ);
                body.push_back(req.reg_addr);
                body.push_back(req.read_count);
            end
            CMD_WRITE: begin
                // An oversized write is swallowed without a single byte.
                if (req.data_count > MAX_WRITE_BYTES) return;
                body.push_back(req.servo_id);
                body.push_back(LEN_WRITE_BASE + {5'd0, req.data_count});
                body.push_back(INS_WRITE);
                body.push_back(req.reg_addr);
                for (int k = 0; k < req.data_count; k++) body.push_back(data[k]);
            end
            default: return;
        endcase
        frame_bytes.push_back('{HDR_BYTE, 1'b0});
        frame_bytes.push_back('{HDR_BYTE, 1'b0});
        foreach (body[k]) begin
            csum = csum + body[k];
            frame_bytes.push_back('{body[k], 1'b0});
        end
        frame_bytes.push_back('{~csum, 1'b1});
    endtask

    function automatic t_sbfb_req make_req(input logic [1:0] cmd, input logic [7:0] id,
                                           input logic [7:0] addr, input logic [7:0] rcnt,
                                           input logic [2:0] dcnt, input logic [7:0] fill);
        t_sbfb_req req;
        req.cmd        = cmd;
        req.servo_id   = id;
        req.reg_addr   = addr;
        req.read_count = rcnt;
        req.data_count = dcnt;
        req.data_0     = fill;
        req.data_1     = fill ^ 8'h11;
        req.data_2     = fill ^ 8'h22;
        req.data_3     = fill ^ 8'h44;
        req.data_4     = fill ^ 8'h88;
        req.data_5     = ~fill;
        return req;
    endfunction

    function automatic t_sbfb_req random_req();
        t_sbfb_req  req;
        int         pick;
        req.servo_id   = 8'($urandom);
        req.reg_addr   = 8'($urandom);
        req.read_count = 8'($urandom);
        req.data_count = 3'($urandom_range(0, 7));
        req.data_0     = 8'($urandom);
        req.data_1     = 8'($urandom);
        req.data_2     = 8'($urandom);
        req.data_3     = 8'($urandom);
        req.data_4     = 8'($urandom);
        req.data_5     = 8'($urandom);
        // Mostly well-formed frames, with an occasional unused kind code.
        pick = $urandom_range(0, 19);
        if (pick < 6) req.cmd = CMD_PING;
        else if (pick < 12) req.cmd = CMD_READ;
        else if (pick < 19) req.cmd = CMD_WRITE;
        else req.cmd = CMD_UNUSED;
        return req;
    endfunction

    task automatic queue_request(input t_sbfb_req req, input int idle, input bit drain);
        t_pending_req item;
        item.req         = req;
        item.idle_cycles = idle;
        item.wait_drain  = drain;
        pending_reqs.push_back(item);
    endtask

    // Driver. A request is held on the inputs until the block takes it; only
    // once it has been taken (or while nothing is being offered) does the
    // driver decide whether to idle, hold back for a drain, or send the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            idle_left = 0;
        end else if (!(i_start && o_busy)) begin
            if (idle_left > 0) begin
                idle_left--;
                i_start <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                i_start <= 1'b0;
            end else if (pending_reqs[0].idle_cycles > 0) begin
                idle_left = pending_reqs[0].idle_cycles - 1;
                pending_reqs[0].idle_cycles = 0;
                i_start <= 1'b0;
            end else if (pending_reqs[0].wait_drain &&
                         (bytes_outstanding != 0 || (i_start && !o_busy))) begin
                // A request taken at this very edge is not yet counted as
                // outstanding, so a drain also waits out that edge.
                i_start <= 1'b0;
            end else begin
                i_req   <= pending_reqs[0].req;
                i_start <= 1'b1;
                void'(pending_reqs.pop_front());
            end
        end
    end

    // Monitor. Both the prediction and the checking live here, so the store of
    // expected bytes is only ever touched by one process. The counts that the
    // driver and the sequencer read are updated with nonblocking assignments,
    // which keeps their view of this edge independent of process order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (frame_bytes.size() == 0) begin
                    log_mismatch($sformatf("unexpected byte %02h last %0b",
                                           o_res.tx_byte, o_res.last));
                end else begin
                    want_byte = frame_bytes.pop_front();
                    if (o_res.tx_byte !== want_byte.tx_byte)
                        log_mismatch($sformatf("tx_byte %02h, expected %02h",
                                               o_res.tx_byte, want_byte.tx_byte));
                    if (o_res.last !== want_byte.last)
                        log_mismatch($sformatf("last %0b, expected %0b",
                                               o_res.last, want_byte.last));
                end
            end
            if (i_start && !o_busy) begin
                build_frame(i_req);
                requests_taken <= requests_taken + 1;
            end
            bytes_outstanding <= frame_bytes.size();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("servo_bus_frame_builder_core test failed");
            $finish;
        end
    end

    // Sequencer. The whole list of requests is built at time zero, before the
    // reset is released, so the driver never runs dry in the middle of a phase.
    initial begin
        int idle;

        // Directed part: both ends of every field, each kind of frame, every
        // write length including the empty one, an oversized write, and the
        // unused kind code. Fields that a frame ignores are set to odd values
        // so that any leak of them into the frame shows up.
        queue_request(make_req(CMD_PING, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_PING, 8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF), 0, 1'b0);
        queue_request(make_req(CMD_READ, 8'h01, 8'h00, 8'h00, 3'd0, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_READ, 8'hFE, 8'hFF, 8'hFF, 3'd7, 8'hFF), 0, 1'b0);
        queue_request(make_req(CMD_READ, 8'h7F, 8'h38, 8'h02, 3'd3, 8'h5A), 2, 1'b0);
        for (int n = 0; n <= MAX_WRITE_BYTES; n++)
            queue_request(make_req(CMD_WRITE, 8'h01, 8'h2A, 8'hC3, 3'(n), 8'hA5), 0, 1'b0);
        queue_request(make_req(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 3'd6, 8'hFF), 0, 1'b0);
        queue_request(make_req(CMD_WRITE, 8'h00, 8'h00, 8'h00, 3'd6, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_WRITE, 8'h10, 8'h20, 8'h30, 3'd7, 8'hFF), 0, 1'b0);
        queue_request(make_req(CMD_PING, 8'h05, 8'h00, 8'h00, 3'd0, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF), 0, 1'b0);
        queue_request(make_req(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_READ, 8'h33, 8'h80, 8'h01, 3'd0, 8'h00), 0, 1'b0);
        queue_request(make_req(CMD_WRITE, 8'hC0, 8'h7F, 8'h00, 3'd2, 8'h5A), 3, 1'b0);
        queue_request(make_req(CMD_WRITE, 8'h80, 8'h01, 8'h00, 3'd1, 8'h80), 0, 1'b0);

        // Random part. Idling comes in bursts ahead of about a third of the
        // requests, except over the closing stretch, which runs flat out. A
        // few requests wait for the frame stream to empty completely first.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idle = 0;
            if (n < NO_IDLE_FROM && $urandom_range(0, 99) < 35) idle = $urandom_range(1, 9);
            queue_request(random_req(), idle, n == 0 || n == 90 || n == 150);
        end
        total_requests = pending_reqs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been taken and every byte has come.
        do @(posedge i_clk);
        while (requests_taken != total_requests || bytes_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (frame_bytes.size() != 0)
            log_mismatch($sformatf("%0d expected bytes never arrived", frame_bytes.size()));
        if (error_count == 0) begin
            $display("servo_bus_frame_builder_core test passed");
        end else begin
            $display("servo_bus_frame_builder_core test failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sbfb_pkg.sv
design/sbfb_dp.sv
design/sbfb_ctrl.sv
design/servo_bus_frame_builder_core.sv
bench/servo_bus_frame_builder_core_test.sv
